// ===== src/ldeq_pkg.sv =====
// ----------------------------------------------------------------------------
// ldeq_pkg
// Shared sizes, request and status codes, and the control bundle that the
// decision logic hands to the top level of the linear deque engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ldeq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_REAR   = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFRONT = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  // Everything one request decides: pointer updates, the store access and
  // the parts of the result that do not come from the store.
  typedef struct packed {
    logic [IDX_W-1:0]  front_next;
    logic [IDX_W-1:0]  rear_next;
    logic              empty_next;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic              use_store;
    logic [DATA_W-1:0] imm_value;
    logic [ST_W-1:0]   status;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== src/ldeq_store.sv =====
// ----------------------------------------------------------------------------
// ldeq_store
// Element store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ldeq_store (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ldeq_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [ldeq_pkg::DATA_W-1:0] wr_data,
  input  wire logic [ldeq_pkg::IDX_W-1:0] rd_addr,
  output logic [ldeq_pkg::DATA_W-1:0]     rd_data
);
  import ldeq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A request that writes the store never uses the read data, so
  // read-during-write behavior does not matter.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/ldeq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ldeq_ctrl
// Request decision logic: checks the ends of the deque and works out the
// pointer moves, the store access and the status of one request.
// ----------------------------------------------------------------------------
`default_nettype none
module ldeq_ctrl (
  input  wire logic [ldeq_pkg::OP_W-1:0]   op,
  input  wire logic [ldeq_pkg::DATA_W-1:0] value_in,
  input  wire logic [ldeq_pkg::IDX_W-1:0]  front,
  input  wire logic [ldeq_pkg::IDX_W-1:0]  rear,
  input  wire logic                        empty,
  output ldeq_pkg::ctrl_t                  ctrl
);
  import ldeq_pkg::*;

  logic full;
  logic is_front_op;

  assign full = !empty && (rear == LAST_IDX);
  assign is_front_op = (op == OP_REM_FRONT) || (op == OP_PEEK_FRONT);

  always_comb begin
    ctrl            = '0;
    ctrl.front_next = front;
    ctrl.rear_next  = rear;
    ctrl.empty_next = empty;
    ctrl.rd_addr    = is_front_op ? front : rear;
    ctrl.status     = ST_OK;

    unique case (op)
      OP_INS_FRONT, OP_INS_REAR: begin
        ctrl.imm_value = value_in;
        if (full) begin
          ctrl.status = ST_FULL;
        end else if (empty) begin
          ctrl.front_next = '0;
          ctrl.rear_next  = '0;
          ctrl.empty_next = 1'b0;
          ctrl.wr_en      = 1'b1;
          ctrl.wr_addr    = '0;
        end else if (op == OP_INS_FRONT) begin
          if (front == '0) begin
            ctrl.status = ST_NOFRONT;
          end else begin
            ctrl.front_next = front - 1'b1;
            ctrl.wr_en      = 1'b1;
            ctrl.wr_addr    = front - 1'b1;
          end
        end else begin
          ctrl.rear_next = rear + 1'b1;
          ctrl.wr_en     = 1'b1;
          ctrl.wr_addr   = rear + 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (empty) begin
          ctrl.imm_value = '1;
          ctrl.status    = ST_EMPTY;
        end else begin
          ctrl.use_store = 1'b1;
          if (op == OP_REM_FRONT || op == OP_REM_REAR) begin
            if (front == rear) begin
              ctrl.front_next = '0;
              ctrl.rear_next  = '0;
              ctrl.empty_next = 1'b1;
            end else if (op == OP_REM_FRONT) begin
              ctrl.front_next = front + 1'b1;
            end else begin
              ctrl.rear_next = rear - 1'b1;
            end
          end
        end
      end
      default: begin
        // Unused request codes leave the deque alone and answer zero.
        ctrl.imm_value = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/linear_deque_engine_unit.sv =====
// ----------------------------------------------------------------------------
// linear_deque_engine_unit
// Double-ended queue kept in a linear, non-circular store of DEPTH words.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge where start is high and busy is low;
// busy is high only while reset is applied, so the block takes one item per
// cycle, back to back. Each item produces exactly one result, shown on
// value_out, status, now_empty and now_full for the single cycle in which done
// is high: the cycle right after the item was taken. The receiver cannot hold
// results off, so it must capture them in that cycle. The result lags the item
// because the element store's read data is registered; pointer updates
// happen at the edge that takes the item, so the next item already sees them.
// Because the store is linear, an insert reports full whenever the rear end
// sits at the last slot, even for a front insert, and a front insert reports
// no space when the front end sits at slot zero. Removing the last element
// returns both ends to slot zero. Removing or peeking an empty deque returns
// -1 with the empty status.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_deque_engine_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ldeq_pkg::OP_W-1:0]   op,
  input  wire logic signed [ldeq_pkg::DATA_W-1:0] value_in,
  output logic                             done,
  output logic signed [ldeq_pkg::DATA_W-1:0] value_out,
  output logic [ldeq_pkg::ST_W-1:0]        status,
  output logic                             now_empty,
  output logic                             now_full
);
  import ldeq_pkg::*;

  // Deque end pointers and the empty flag.
  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] rear;
  logic             empty;

  // Result register; the store data joins it through the value select.
  logic              use_store;
  logic [DATA_W-1:0] imm_value;
  logic [DATA_W-1:0] rd_data;

  ctrl_t ctrl;
  logic  accept;

  assign busy   = rst;
  assign accept = start && !busy;

  ldeq_ctrl u_ctrl (
    .op       (op),
    .value_in (value_in),
    .front    (front),
    .rear     (rear),
    .empty    (empty),
    .ctrl     (ctrl)
  );

  ldeq_store u_store (
    .clk     (clk),
    .wr_en   (accept && ctrl.wr_en),
    .wr_addr (ctrl.wr_addr),
    .wr_data (value_in),
    .rd_addr (ctrl.rd_addr),
    .rd_data (rd_data)
  );

  // Pointer state moves at the edge that takes the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
    end else if (accept) begin
      front <= ctrl.front_next;
      rear  <= ctrl.rear_next;
      empty <= ctrl.empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Payload of the result; the flags describe the deque after the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      use_store <= ctrl.use_store;
      imm_value <= ctrl.imm_value;
      status    <= ctrl.status;
      now_empty <= ctrl.empty_next;
      now_full  <= !ctrl.empty_next && (ctrl.rear_next == LAST_IDX);
    end
  end

  assign value_out = use_store ? rd_data : imm_value;

endmodule
`default_nettype wire

// ===== src/ldeq_checker.sv =====
// ----------------------------------------------------------------------------
// ldeq_checker
// Port-level checks of the linear deque engine, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ldeq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [ldeq_pkg::OP_W-1:0]   op,
  input wire logic [ldeq_pkg::DATA_W-1:0] value_in,
  input wire logic                        done,
  input wire logic [ldeq_pkg::DATA_W-1:0] value_out,
  input wire logic [ldeq_pkg::ST_W-1:0]   status,
  input wire logic                        now_empty,
  input wire logic                        now_full
);
  import ldeq_pkg::*;

  // Every taken item gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("item taken without a result");

  // No result appears without an item taken in the cycle before.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without an item");

  // A full deque cannot also be empty.
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> !(now_full && now_empty))
    else $error("full and empty at once");

  // An empty answer leaves the deque empty and returns all ones.
  a_empty_answer: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (now_empty && value_out == '1))
    else $error("bad empty answer");

  // An insert always echoes the inserted value.
  a_insert_echo: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_INS_FRONT || op == OP_INS_REAR))
      |=> (value_out == $past(value_in)))
    else $error("insert did not echo its value");

endmodule

bind linear_deque_engine_unit ldeq_checker u_ldeq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .op        (op),
  .value_in  (value_in),
  .done      (done),
  .value_out (value_out),
  .status    (status),
  .now_empty (now_empty),
  .now_full  (now_full)
);
`default_nettype wire

// ===== verif/tb_linear_deque_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_deque_engine_unit
// Self-checking bench for the linear deque engine. A short table of directed
// items walks the empty, full and no-space-at-front corners. A long random
// run then alternates between filling and draining phases, so the deque
// hits both ends of its store many times. A cycle-accurate predictor checks
// every result that the table does not type in by hand.
// ----------------------------------------------------------------------------
module tb_linear_deque_engine_unit;
  import ldeq_pkg::*;

  // The two op codes that the block does not define. They are still legal
  // input values, so the bench drives them too.
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  // One result, as the block presents it on its four result ports.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [ST_W-1:0]   status;
    logic              empty;
    logic              full;
  } result_t;

  // A row of the directed table. When has_value is set, the row carries an
  // expected result that is typed in by hand. Otherwise the predictor
  // supplies the expected result. The row is sent reps times, and the value
  // is stepped by one on each repeat.
  typedef struct {
    logic [OP_W-1:0]   code;
    logic [DATA_W-1:0] data;
    int                reps;
    bit                has_value;
    result_t           res;
  } plan_row_t;

  // Tag that goes with each item sent, in send order. It says whether a
  // hand-typed result replaces the predicted one.
  typedef struct packed {
    bit      has_value;
    result_t res;
  } tag_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   op = OP_INS_FRONT;
  logic signed [DATA_W-1:0] value_in = '0;
  logic              done;
  logic signed [DATA_W-1:0] value_out;
  logic [ST_W-1:0]   status;
  logic              now_empty;
  logic              now_full;

  linear_deque_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .value_in  (value_in),
    .done      (done),
    .value_out (value_out),
    .status    (status),
    .now_empty (now_empty),
    .now_full  (now_full)
  );

  always #5 clk = ~clk;

  // The predictor keeps its own copy of the deque: the linear store, the
  // front and rear slots, and a flag for the empty condition. While the
  // deque is empty, both slot indexes are held at zero.
  logic [DATA_W-1:0] slots [DEPTH];
  logic [IDX_W-1:0]  head_idx = '0;
  logic [IDX_W-1:0]  tail_idx = '0;
  bit                is_void  = 1'b1;

  result_t   pending_results [$];
  tag_t      sent_tags [$];
  plan_row_t plan [$];

  bit took_item = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int checked_count = 0;
  int refused_full = 0;
  int refused_front = 0;
  int empty_reads = 0;
  int spare_ops = 0;
  int full_hits = 0;
  int burst_left = 0;

  // This function applies one request to the predicted deque and returns the
  // result that the request should produce. An insert echoes its value. The
  // full check comes first and applies to front inserts too, because the
  // store does not wrap around.
  function automatic result_t deque_apply(input logic [OP_W-1:0] code,
                                          input logic [DATA_W-1:0] data);
    result_t r;
    r.value  = '0;
    r.status = ST_OK;
    case (code)
      OP_INS_FRONT, OP_INS_REAR: begin
        r.value = data;
        if (!is_void && tail_idx == LAST_IDX) begin
          r.status = ST_FULL;
        end else if (is_void) begin
          head_idx = '0;
          tail_idx = '0;
          is_void  = 1'b0;
          slots[0] = data;
        end else if (code == OP_INS_FRONT) begin
          if (head_idx == '0) begin
            r.status = ST_NOFRONT;
          end else begin
            head_idx = head_idx - 1'b1;
            slots[head_idx] = data;
          end
        end else begin
          tail_idx = tail_idx + 1'b1;
          slots[tail_idx] = data;
        end
      end
      OP_REM_FRONT, OP_REM_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (is_void) begin
          r.value  = '1;
          r.status = ST_EMPTY;
        end else begin
          if (code == OP_REM_FRONT || code == OP_PEEK_FRONT) begin
            r.value = slots[head_idx];
          end else begin
            r.value = slots[tail_idx];
          end
          if (code == OP_REM_FRONT || code == OP_REM_REAR) begin
            // When the last element is removed, both ends go back to slot zero.
            if (head_idx == tail_idx) begin
              head_idx = '0;
              tail_idx = '0;
              is_void  = 1'b1;
            end else if (code == OP_REM_FRONT) begin
              head_idx = head_idx + 1'b1;
            end else begin
              tail_idx = tail_idx - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.empty = is_void;
    r.full  = !is_void && tail_idx == LAST_IDX;
    return r;
  endfunction

  // The monitor runs on the rising edge and reads the values that were
  // present before the edge. It first retires a result, if one is shown,
  // and then records the item that this edge accepts. A result always
  // belongs to an item that was accepted at an earlier edge.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    result_t pred;
    tag_t    tag;
    if (!rst && done) begin
      got = '{value_out, status, now_empty, now_full};
      checked_count++;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: value_out=%0d status=%0d",
               value_out, status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) begin
          $error("value_out: expected %0d, got %0d", $signed(want.value),
                 $signed(got.value));
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.empty !== want.empty) begin
          $error("now_empty: expected %0b, got %0b", want.empty, got.empty);
          error_count++;
        end
        if (got.full !== want.full) begin
          $error("now_full: expected %0b, got %0b", want.full, got.full);
          error_count++;
        end
      end
    end
    took_item = start && !busy && !rst;
    if (took_item) begin
      pred = deque_apply(op, value_in);
      tag = sent_tags.pop_front();
      pending_results.push_back(tag.has_value ? tag.res : pred);
      if (pred.status == ST_FULL) refused_full++;
      if (pred.status == ST_NOFRONT) refused_front++;
      if (pred.status == ST_EMPTY) empty_reads++;
      if (op == OP_SPARE6 || op == OP_SPARE7) spare_ops++;
      if (pred.full) full_hits++;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // The watchdog ends a run that has hung.
  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("tb_linear_deque_engine_unit: done, errors");
    $finish;
  end

  // This task sends one item. The call comes at a falling edge, and the task
  // returns at the falling edge after the item has been accepted. The sender
  // works in bursts. Before each burst there is a random gap, and the gap is
  // sometimes zero. Now and then a long burst leaves a stretch with no idle
  // cycles at all.
  task automatic send_item(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] data,
                           input bit has_value, input result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    sent_tags.push_back('{has_value, res});
    start    <= 1'b1;
    op       <= code;
    value_in <= data;
    @(negedge clk);
    while (!took_item) @(negedge clk);
  endtask

  function automatic void plan_row(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] data,
                                   input int reps, input bit has_value,
                                   input logic [DATA_W-1:0] value, input logic [ST_W-1:0] st,
                                   input logic empty, input logic full);
    plan.push_back('{code, data, reps, has_value, '{value, st, empty, full}});
  endfunction

  // Most values are fully random. About two values in five are an extreme
  // of the signed range, zero, or all ones.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    int real_items;
    int phase_left;
    bit filling;
    int pick;
    logic [OP_W-1:0] code;

    // The columns are: op, value, repeats, typed or predicted, then the
    // hand-typed value_out, status, now_empty and now_full.
    plan_row(OP_PEEK_FRONT, 32'h1234_5678, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1, 0);
    plan_row(OP_PEEK_REAR,  32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1, 0);
    plan_row(OP_REM_FRONT,  32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1, 0);
    plan_row(OP_REM_REAR,   32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1, 0);
    plan_row(OP_SPARE6,     32'hFFFF_FFFF, 1, 1, 32'h0000_0000, ST_OK,    1, 0);
    plan_row(OP_SPARE7,     32'h0000_0000, 1, 1, 32'h0000_0000, ST_OK,    1, 0);
    // The first insert goes into an empty deque and lands at slot zero. A
    // second front insert then has no room.
    plan_row(OP_INS_FRONT,  32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, ST_OK,      0, 0);
    plan_row(OP_INS_FRONT,  32'h8000_0000, 1, 1, 32'h8000_0000, ST_NOFRONT, 0, 0);
    plan_row(OP_INS_REAR,   32'h8000_0000, 1, 1, 32'h8000_0000, ST_OK,      0, 0);
    plan_row(OP_PEEK_FRONT, 32'h0000_0000, 1, 1, 32'h7FFF_FFFF, ST_OK,      0, 0);
    plan_row(OP_PEEK_REAR,  32'h0000_0000, 1, 1, 32'h8000_0000, ST_OK,      0, 0);
    plan_row(OP_REM_FRONT,  32'h0000_0000, 1, 1, 32'h7FFF_FFFF, ST_OK,      0, 0);
    // Refill slot zero, then push the rear end up to the last slot.
    plan_row(OP_INS_FRONT,  32'h0000_0000, 1, 0, '0, ST_OK, 0, 0);
    plan_row(OP_INS_REAR,   32'hA5A5_0000, DEPTH - 2, 0, '0, ST_OK, 0, 0);
    // With the rear at the last slot, both kinds of insert are refused as
    // full. A spare op code reports the full condition without changing it.
    plan_row(OP_INS_REAR,   32'h5A5A_5A5A, 1, 1, 32'h5A5A_5A5A, ST_FULL, 0, 1);
    plan_row(OP_INS_FRONT,  32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, ST_FULL, 0, 1);
    plan_row(OP_SPARE7,     32'h1357_9BDF, 1, 1, 32'h0000_0000, ST_OK,   0, 1);
    // Drain the deque from both ends down to its last element.
    plan_row(OP_REM_REAR,   32'h0000_0000, 1, 0, '0, ST_OK, 0, 0);
    plan_row(OP_REM_FRONT,  32'h0000_0000, DEPTH - 2, 0, '0, ST_OK, 0, 0);
    plan_row(OP_PEEK_REAR,  32'h0000_0000, 1, 0, '0, ST_OK, 0, 0);
    plan_row(OP_REM_REAR,   32'h0000_0000, 1, 0, '0, ST_OK, 0, 0);
    plan_row(OP_REM_FRONT,  32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_EMPTY, 1, 0);
    plan_row(OP_INS_REAR,   32'h0000_0001, 1, 1, 32'h0000_0001, ST_OK,    0, 0);

    // Synchronous reset is held first. Inputs change only on the
    // falling edge from here on.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        send_item(plan[i].code, plan[i].data + k, plan[i].has_value, plan[i].res);
      end
    end

    // In the random part, filling and draining phases take turns. A filling
    // phase drives the rear end into the last slot. A draining phase empties
    // the deque and moves the front end up, which makes room for front
    // inserts. Spare op codes are mixed in as noise and are not counted.
    real_items = 0;
    phase_left = 0;
    filling = 1'b1;
    while (real_items < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (filling) begin
        if (pick < 40) code = OP_INS_REAR;
        else if (pick < 62) code = OP_INS_FRONT;
        else if (pick < 75) code = OP_REM_FRONT;
        else if (pick < 84) code = OP_REM_REAR;
        else if (pick < 97) code = pick[0] ? OP_PEEK_FRONT : OP_PEEK_REAR;
        else code = pick[0] ? OP_SPARE6 : OP_SPARE7;
      end else begin
        if (pick < 14) code = OP_INS_REAR;
        else if (pick < 25) code = OP_INS_FRONT;
        else if (pick < 55) code = OP_REM_FRONT;
        else if (pick < 80) code = OP_REM_REAR;
        else if (pick < 97) code = pick[0] ? OP_PEEK_FRONT : OP_PEEK_REAR;
        else code = pick[0] ? OP_SPARE6 : OP_SPARE7;
      end
      send_item(code, pick_value(), 1'b0, '0);
      if (code != OP_SPARE6 && code != OP_SPARE7) real_items++;
    end
    start <= 1'b0;

    // After the last result has come in, the bench waits out a drain period,
    // so that a stray strobe would still be caught.
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d results: %0d inserts refused as full, %0d refused at the front,",
             checked_count, refused_full, refused_front);
    $display("%0d reads of an empty deque, %0d spare op codes, %0d results at the last slot.",
             empty_reads, spare_ops, full_hits);
    if (error_count == 0) begin
      $display("tb_linear_deque_engine_unit: done, clean");
    end else begin
      $display("tb_linear_deque_engine_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== linear_deque_engine_unit.f =====
src/ldeq_pkg.sv
src/ldeq_store.sv
src/ldeq_ctrl.sv
src/linear_deque_engine_unit.sv
src/ldeq_checker.sv
verif/tb_linear_deque_engine_unit.sv
